// ===== hw/rtl/mexp_pkg.sv =====
package mexp_pkg;

  // Field widths.
  localparam int EXP_BITS = 63;
  localparam int MOD_BITS = 31;
  localparam int PAD_BITS = EXP_BITS - MOD_BITS;
  localparam int CNT_W    = $clog2(EXP_BITS + 1);

  // The modulus after reset, a prime.
  localparam logic [MOD_BITS-1:0] MOD_RESET = MOD_BITS'(1000000007);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SQUARE,
    ST_MULT,
    ST_DONE
  } mexp_state_t;

  // Request to the serial multiply-reduce unit.
  typedef struct packed {
    logic start;
    logic wide;
  } mexp_mm_req_t;

  // Status back from the serial multiply-reduce unit.
  typedef struct packed {
    logic busy;
    logic done;
  } mexp_mm_stat_t;

endpackage

// ===== hw/rtl/mexp_mulmod.sv =====
module mexp_mulmod
  import mexp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  mexp_mm_req_t        req,
  input  logic [MOD_BITS-1:0] mod_i,
  input  logic [MOD_BITS-1:0] a_i,
  input  logic [EXP_BITS-1:0] mult_i,
  output mexp_mm_stat_t       stat,
  output logic [MOD_BITS-1:0] res_o
);

  // Computes a * mult mod m, one multiplier bit per cycle, most significant
  // bit first. A wide request scans all EXP_BITS bits of mult_i, a short one
  // only its low MOD_BITS bits. Both a and the accumulator stay below m.

  logic [MOD_BITS-1:0] acc_r, acc_nxt;
  logic [MOD_BITS-1:0] a_r, a_nxt;
  logic [EXP_BITS-1:0] mult_r, mult_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;

  logic [MOD_BITS:0] m_ext;
  logic [MOD_BITS:0] dbl;
  logic [MOD_BITS:0] dbl_red;
  logic [MOD_BITS:0] sum;
  logic [MOD_BITS:0] sum_red;

  always_comb begin
    m_ext   = {1'b0, mod_i};
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
    sum     = dbl_red + (mult_r[EXP_BITS-1] ? {1'b0, a_r} : '0);
    sum_red = (sum >= m_ext) ? sum - m_ext : sum;
  end

  always_comb begin
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    mult_nxt = mult_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      acc_nxt  = '0;
      a_nxt    = a_i;
      busy_nxt = 1'b1;
      if (req.wide) begin
        mult_nxt = mult_i;
        cnt_nxt  = CNT_W'(EXP_BITS);
      end else begin
        mult_nxt = {mult_i[MOD_BITS-1:0], {PAD_BITS{1'b0}}};
        cnt_nxt  = CNT_W'(MOD_BITS);
      end
    end else if (busy_r) begin
      acc_nxt  = sum_red[MOD_BITS-1:0];
      mult_nxt = {mult_r[EXP_BITS-2:0], 1'b0};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    a_r    <= a_nxt;
    mult_r <= mult_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign res_o     = acc_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("multiply started while busy");

  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0)
    else $error("busy with an empty bit count");

  a_res_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && mod_i >= MOD_BITS'(2) && $stable(mod_i)) |-> acc_r < mod_i)
    else $error("product not reduced below the modulus");

endmodule

// ===== hw/rtl/modular_exponentiation.sv =====
// Each accepted word yields one result word. The base is first reduced, then
// the 63 exponent bits are scanned, each bit with a square and, when set, a
// multiply, all on one bit-serial multiply-reduce unit. The next input word
// is taken only after the result register is loaded and the block is idle
// again, so words do not overlap. A modulus below 2 gives a result of zero without using the multiply unit.
// Reset (synchronous, rst_n low): idle, no result pending, modulus 1000000007.
module modular_exponentiation
  import mexp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // Input channel.
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [EXP_BITS-1:0] in_base_value,
  input  logic [EXP_BITS-1:0] in_exponent,
  // Result channel.
  output logic                out_valid,
  input  logic                out_stall,
  output logic [MOD_BITS-1:0] out_power_residue,
  // Modulus write channel.
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [MOD_BITS-1:0] cfg_modulus
);

  // The exponent is scanned from its most significant bit down. For every
  // bit the running residue is squared, and when the bit is set it is then
  // multiplied by the reduced base. Every modular product is formed one
  // multiplier bit per cycle by mexp_mulmod. The base itself is reduced by
  // running it through the same unit as 1 * base mod m.

  mexp_state_t state_r, state_nxt;

  logic [MOD_BITS-1:0] mod_r;
  logic [EXP_BITS-1:0] exp_r, exp_nxt;
  logic [MOD_BITS-1:0] base_r, base_nxt;
  logic [MOD_BITS-1:0] res_r, res_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [MOD_BITS-1:0] out_res_r, out_res_nxt;

  mexp_mm_req_t        mm_req;
  mexp_mm_stat_t       mm_stat;
  logic [MOD_BITS-1:0] mm_res;
  logic [MOD_BITS-1:0] mm_a;
  logic [EXP_BITS-1:0] mm_mult;

  logic                in_take;
  logic                step;
  logic                load_out;

  // Configuration is taken only while idle, and an input word is stalled while
  // a write is pending, so the modulus never changes under a computation.
  assign cfg_ready = (state_r == ST_IDLE);
  assign in_stall  = (state_r != ST_IDLE) || cfg_valid;
  assign in_take   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    exp_nxt   = exp_r;
    base_nxt  = base_r;
    res_nxt   = res_r;
    cnt_nxt   = cnt_r;
    mm_req    = '0;
    mm_a      = res_r;
    mm_mult   = EXP_BITS'(res_r);
    step      = 1'b0;
    load_out  = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          exp_nxt = in_exponent;
          cnt_nxt = CNT_W'(EXP_BITS);
          if (mod_r < MOD_BITS'(2)) begin
            // A modulus of zero or one leaves nothing but zero.
            res_nxt   = '0;
            state_nxt = ST_DONE;
          end else begin
            mm_req.start = 1'b1;
            mm_req.wide  = 1'b1;
            mm_a         = MOD_BITS'(1);
            mm_mult      = in_base_value;
            state_nxt    = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (mm_stat.done) begin
          // The residue starts at one; its first square is issued at once.
          base_nxt     = mm_res;
          res_nxt      = MOD_BITS'(1);
          mm_req.start = 1'b1;
          mm_a         = MOD_BITS'(1);
          mm_mult      = EXP_BITS'(1);
          state_nxt    = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (mm_stat.done) begin
          res_nxt = mm_res;
          if (exp_r[EXP_BITS-1]) begin
            mm_req.start = 1'b1;
            mm_a         = mm_res;
            mm_mult      = EXP_BITS'(base_r);
            state_nxt    = ST_MULT;
          end else begin
            step = 1'b1;
          end
        end
      end
      ST_MULT: begin
        if (mm_stat.done) begin
          res_nxt = mm_res;
          step    = 1'b1;
        end
      end
      ST_DONE: begin
        // Hand the residue to the output register once it is free.
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // Move on to the next exponent bit, or finish after the last one.
    if (step) begin
      exp_nxt = {exp_r[EXP_BITS-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        state_nxt = ST_DONE;
      end else begin
        mm_req.start = 1'b1;
        mm_a         = mm_res;
        mm_mult      = EXP_BITS'(mm_res);
        state_nxt    = ST_SQUARE;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res_r;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    exp_r     <= exp_nxt;
    base_r    <= base_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mod_r       <= MOD_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        mod_r <= cfg_modulus;
      end
    end
  end

  mexp_mulmod u_mulmod (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (mm_req),
    .mod_i  (mod_r),
    .a_i    (mm_a),
    .mult_i (mm_mult),
    .stat   (mm_stat),
    .res_o  (mm_res)
  );

  assign out_valid         = out_valid_r;
  assign out_power_residue = out_res_r;

  a_take_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> state_r != ST_IDLE)
    else $error("accepted word did not start a computation");

  a_mod_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |=> $stable(mod_r))
    else $error("modulus changed during a computation");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && (!out_valid_r || !out_stall))
      |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished residue not moved to the output register");

  a_unit_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    mm_stat.busy |-> (state_r == ST_REDUCE || state_r == ST_SQUARE ||
                      state_r == ST_MULT))
    else $error("multiply unit busy outside a computation");

endmodule
